### rtl/ebs_pkg.sv
// ----------------------------------------------------------------------------
// ebs_pkg
// shared types and constants of the eviction batch sizer
// ----------------------------------------------------------------------------
package ebs_pkg;

	localparam int EBS_MAX_CLASSES = 64;

	localparam int SLAB_W  = 20;
	localparam int FRAC_W  = 17;
	localparam int IPS_W   = 16;
	localparam int NEED_W  = 36;
	localparam int BATCH_W = 20;
	localparam int CUR_W   = 18;
	localparam int HALF_W  = 18;
	localparam int DCNT_W  = $clog2(BATCH_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [FRAC_W-1:0]  FULL_Q16        = 17'h10000;
	localparam logic [SLAB_W-1:0]  FREE_SLAB_LIMIT = 20'd2;
	localparam logic [FRAC_W-1:0]  HWM_RESET       = 17'd1311;
	localparam logic [BATCH_W-1:0] MAX_BATCH_RESET = 20'd1000;
	localparam logic [BATCH_W-1:0] MIN_BATCH_RESET = 20'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HWM       = 2'd0,
		CFG_MAX_BATCH = 2'd1,
		CFG_MIN_BATCH = 2'd2
	} ebs_cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LO,
		S_HI,
		S_SUM,
		S_SUB,
		S_WR,
		S_RD,
		S_NLO,
		S_NHI,
		S_NSUM,
		S_DIV,
		S_FIN,
		S_OUT
	} ebs_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic lo;
		logic hi;
		logic sum;
		logic sub;
		logic wr;
		logic rd;
		logic nlo;
		logic nhi;
		logic nsum;
		logic div;
		logic fin;
		logic emit;
	} ebs_cmd_t;

	typedef struct packed {
		logic full;
		logic last_rec;
		logic div_done;
		logic out_free;
		logic emit_last;
	} ebs_status_t;

endpackage

### rtl/ebs_ram.sv
// ----------------------------------------------------------------------------
// ebs_ram
// generic single write, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ebs_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/ebs_datapath.sv
// ----------------------------------------------------------------------------
// ebs_datapath
// need computation, need store, running maximum, batch divider and output beat
// ----------------------------------------------------------------------------
module ebs_datapath import ebs_pkg::*; #(
	parameter int MAX_CLASSES = EBS_MAX_CLASSES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ebs_cmd_t             cmd,
	output ebs_status_t          status,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BATCH_W-1:0]   cfg_data,
	input  logic [SLAB_W-1:0]    pool_free_slabs,
	input  logic [SLAB_W-1:0]    class_free_slabs,
	input  logic [FRAC_W-1:0]    usage_q16,
	input  logic                 all_allocated,
	input  logic [SLAB_W-1:0]    class_slabs,
	input  logic [IPS_W-1:0]     items_per_slab,
	input  logic                 last_class,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BATCH_W-1:0]   batch_size,
	output logic                 last_batch
);
	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int PW = FRAC_W + HALF_W;
	localparam int NW = BATCH_W + HALF_W;

	// configuration
	logic [FRAC_W-1:0]  hwm_q;
	logic [BATCH_W-1:0] max_batch_q;
	logic [BATCH_W-1:0] min_batch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q       <= HWM_RESET;
			max_batch_q <= MAX_BATCH_RESET;
			min_batch_q <= MIN_BATCH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HWM:       hwm_q       <= cfg_data[FRAC_W-1:0];
				CFG_MAX_BATCH: max_batch_q <= cfg_data;
				CFG_MIN_BATCH: min_batch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// record registers
	logic [SLAB_W-1:0] pool_q, cls_free_q, slabs_q;
	logic [FRAC_W-1:0] usage_q;
	logic              alloc_q, last_q;
	logic [IPS_W-1:0]  ips_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pool_q     <= pool_free_slabs;
			cls_free_q <= class_free_slabs;
			usage_q    <= usage_q16;
			alloc_q    <= all_allocated;
			slabs_q    <= class_slabs;
			ips_q      <= items_per_slab;
			last_q     <= last_class;
		end
	end

	// need computation
	logic [FRAC_W-1:0] free_frac;
	logic [NEED_W-1:0] prod_q, tofree_q, need_q;
	logic [CUR_W-1:0]  cur_q;
	logic [FRAC_W-1:0] diff_q;
	logic              elig_q;
	logic [PW-1:0]     plo_q, phi_q;
	logic [PW+HALF_W-1:0] full_sum;
	logic [NEED_W:0]   tofree_w;

	assign free_frac = usage_q[FRAC_W-1] ? '0 : FRAC_W'(FULL_Q16 - usage_q);
	assign full_sum  = {phi_q, {HALF_W{1'b0}}} + (PW+HALF_W)'(plo_q);
	assign tofree_w  = full_sum[PW+HALF_W-1:16];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= NEED_W'(slabs_q) * NEED_W'(ips_q);
			cur_q  <= CUR_W'(cls_free_q[1:0]) * CUR_W'(ips_q);
			diff_q <= FRAC_W'(hwm_q - free_frac);
			elig_q <= (pool_q == '0) && (cls_free_q <= FREE_SLAB_LIMIT) &&
				(free_frac < hwm_q) && alloc_q;
		end
		if (cmd.lo) begin
			plo_q <= PW'(diff_q) * PW'(prod_q[HALF_W-1:0]);
		end
		if (cmd.hi) begin
			phi_q <= PW'(diff_q) * PW'(prod_q[NEED_W-1:HALF_W]);
		end
		if (cmd.sum) begin
			tofree_q <= tofree_w[NEED_W] ? '1 : tofree_w[NEED_W-1:0];
		end
		if (cmd.sub) begin
			need_q <= (elig_q && (tofree_q > NEED_W'(cur_q))) ?
				NEED_W'(tofree_q - NEED_W'(cur_q)) : '0;
		end
	end

	// need store
	logic [CW-1:0]     count_q, emit_q;
	logic [NEED_W-1:0] max_q, rdata;
	logic              emit_last;

	ebs_ram #(
		.WIDTH(NEED_W),
		.DEPTH(MAX_CLASSES)
	) u_need_ram (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(count_q[AW-1:0]),
		.wdata(need_q),
		.re   (cmd.rd),
		.raddr(emit_q[AW-1:0]),
		.rdata(rdata)
	);

	assign emit_last = (CW'(emit_q + CW'(1)) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			emit_q  <= '0;
			max_q   <= '0;
		end else if (cmd.wr) begin
			count_q <= CW'(count_q + CW'(1));
			if (need_q > max_q) begin
				max_q <= need_q;
			end
		end else if (cmd.emit) begin
			if (emit_last) begin
				count_q <= '0;
				emit_q  <= '0;
				max_q   <= '0;
			end else begin
				emit_q <= CW'(emit_q + CW'(1));
			end
		end
	end

	// batch divider, one quotient bit per cycle
	logic [NEED_W-1:0]     need_e_q, rem_q;
	logic [NW-1:0]         nlo_q, nhi_q;
	logic [NW+HALF_W-1:0]  num;
	logic [BATCH_W-1:0]    qsh_q, batch_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic [NEED_W:0]       trial;

	assign num   = {nhi_q, {HALF_W{1'b0}}} + (NW+HALF_W)'(nlo_q);
	assign trial = {rem_q, qsh_q[BATCH_W-1]} - {1'b0, max_q};

	always_ff @(posedge clk) begin
		if (cmd.nlo) begin
			need_e_q <= rdata;
			nlo_q    <= NW'(max_batch_q) * NW'(rdata[HALF_W-1:0]);
		end
		if (cmd.nhi) begin
			nhi_q <= NW'(max_batch_q) * NW'(need_e_q[NEED_W-1:HALF_W]);
		end
		if (cmd.nsum) begin
			rem_q  <= num[NW+HALF_W-1:BATCH_W];
			qsh_q  <= num[BATCH_W-1:0];
			dcnt_q <= '0;
		end
		if (cmd.div) begin
			dcnt_q <= DCNT_W'(dcnt_q + DCNT_W'(1));
			if (!trial[NEED_W]) begin
				rem_q <= trial[NEED_W-1:0];
				qsh_q <= {qsh_q[BATCH_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NEED_W-2:0], qsh_q[BATCH_W-1]};
				qsh_q <= {qsh_q[BATCH_W-2:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			if ((need_e_q == '0) || (max_q == '0)) begin
				batch_q <= '0;
			end else if (qsh_q < min_batch_q) begin
				batch_q <= min_batch_q;
			end else begin
				batch_q <= qsh_q;
			end
		end
	end

	// output beat register
	logic              out_valid_q;
	logic [BATCH_W-1:0] out_batch_q;
	logic              out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_batch_q <= batch_q;
			out_last_q  <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign batch_size = out_batch_q;
	assign last_batch = out_last_q;

	assign status.full      = (count_q == CW'(MAX_CLASSES));
	assign status.last_rec  = last_q;
	assign status.div_done  = (dcnt_q == DCNT_W'(BATCH_W - 1));
	assign status.out_free  = !out_valid_q || out_ready;
	assign status.emit_last = emit_last;
endmodule

### rtl/ebs_ctrl.sv
// ----------------------------------------------------------------------------
// ebs_ctrl
// sequencer for record loading, need storing and per-class batch emission
// ----------------------------------------------------------------------------
module ebs_ctrl import ebs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ebs_status_t status,
	output ebs_cmd_t    cmd
);
	ebs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (status.full) begin
					state_d = status.last_rec ? S_RD : S_IDLE;
				end else begin
					state_d = S_LO;
				end
			end
			S_LO: begin
				cmd.lo  = 1'b1;
				state_d = S_HI;
			end
			S_HI: begin
				cmd.hi  = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_SUB;
			end
			S_SUB: begin
				cmd.sub = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				cmd.wr  = 1'b1;
				state_d = status.last_rec ? S_RD : S_IDLE;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_NLO;
			end
			S_NLO: begin
				cmd.nlo = 1'b1;
				state_d = S_NHI;
			end
			S_NHI: begin
				cmd.nhi = 1'b1;
				state_d = S_NSUM;
			end
			S_NSUM: begin
				cmd.nsum = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (status.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = status.emit_last ? S_IDLE : S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### rtl/eviction_batch_sizer.sv
// ----------------------------------------------------------------------------
// eviction_batch_sizer
// per-class eviction need from slab records, scaled to batch sizes at set end
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | pool_free_slabs .. last_class
//   out     | output    | out_valid/out_ready | batch_size, last_batch
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a record passes through a two-part 17x36 need multiply, sum, subtract, store
// each result is read, scaled, divided one quotient bit per cycle and clamped
// emission of a set starts after its last record
// reset clears the sequencer, counters and running maximum, config to defaults
// an output stall holds the sequencer before the next result beat
// ----------------------------------------------------------------------------
module eviction_batch_sizer import ebs_pkg::*; #(
	parameter int MAX_CLASSES = EBS_MAX_CLASSES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SLAB_W-1:0]    pool_free_slabs,
	input  logic [SLAB_W-1:0]    class_free_slabs,
	input  logic [FRAC_W-1:0]    usage_q16,
	input  logic                 all_allocated,
	input  logic [SLAB_W-1:0]    class_slabs,
	input  logic [IPS_W-1:0]     items_per_slab,
	input  logic                 last_class,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BATCH_W-1:0]   batch_size,
	output logic                 last_batch,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BATCH_W-1:0]   cfg_data
);
	ebs_cmd_t    cmd;
	ebs_status_t status;

	assign cfg_ready = 1'b1;

	ebs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	ebs_datapath #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pool_free_slabs (pool_free_slabs),
		.class_free_slabs(class_free_slabs),
		.usage_q16       (usage_q16),
		.all_allocated   (all_allocated),
		.class_slabs     (class_slabs),
		.items_per_slab  (items_per_slab),
		.last_class      (last_class),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.batch_size      (batch_size),
		.last_batch      (last_batch)
	);

	// one command at a time from the sequencer
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cmd))
		else $error("more than one datapath command");

	// a result beat is loaded only into a free output slot
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> status.out_free)
		else $error("result beat loaded over a pending beat");

	// a record is latched only on an accepted input beat
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_valid && in_ready))
		else $error("record latched without input beat");

	// after a result beat the output is valid
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |=> out_valid)
		else $error("result beat not presented");
endmodule
